### rtl/core/hrle_pkg.sv
// Shared types and constants for the half-byte run-length decoder.
// Used by hrle_lane, hrle_merge and halfbyte_rle_decoder; depends on nothing.
package hrle_pkg;

    // Result queue between the lanes and the output channel.
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int LVLW   = $clog2(QDEPTH + 1);

    // Register indexes on the configuration port.
    localparam logic REG_MODE = 1'b0;

    // Code sets selected by the mode register; any other code acts as three separate codes.
    localparam logic [1:0] MODE_FULL     = 2'd0;
    localparam logic [1:0] MODE_SHORTESC = 2'd1;

    // Code nibbles and length offsets.
    localparam logic [3:0] NIB_SHORT  = 4'd15;
    localparam logic [3:0] NIB_LONG   = 4'd14;
    localparam logic [3:0] NIB_ESC    = 4'd13;
    localparam logic [8:0] SHORT_BIAS = 9'd2;
    localparam logic [8:0] LONG_BIAS  = 9'd18;

    // Token progress: nibbles already taken of the current token; an escape code skips STEP_TWO.
    localparam logic [1:0] STEP_CODE  = 2'd0;
    localparam logic [1:0] STEP_ONE   = 2'd1;
    localparam logic [1:0] STEP_TWO   = 2'd2;
    localparam logic [1:0] STEP_THREE = 2'd3;

    typedef enum logic [1:0] {
        KIND_SHORT = 2'd0,
        KIND_LONG  = 2'd1,
        KIND_ESC   = 2'd2
    } t_kind;

    typedef struct packed {
        logic [1:0] step;
        t_kind      kind;
        logic [3:0] hval;
        logic [3:0] hlow;
    } t_tok;

    typedef struct packed {
        logic       valid;
        logic [7:0] value;
        logic [8:0] count;
    } t_res;

    typedef struct packed {
        logic [LVLW-1:0] level;
        logic            room;
    } t_q_stat;

    localparam t_tok TOK_RESET = '{step: STEP_CODE, kind: KIND_SHORT, hval: 4'd0, hlow: 4'd0};

endpackage

### rtl/core/hrle_lane.sv
// One nibble step of the token parser: next token state and an optional run descriptor.
// Depends on hrle_pkg.
module hrle_lane (
    input  logic [1:0]    i_mode,
    input  hrle_pkg::t_tok i_tok,
    input  logic [3:0]    i_nib,
    output hrle_pkg::t_tok o_tok,
    output hrle_pkg::t_res o_res
);
    import hrle_pkg::*;

    logic low_mode;

    assign low_mode = (i_mode == MODE_FULL) || (i_mode == MODE_SHORTESC);

    always_comb begin
        o_tok = i_tok;
        o_res = '0;
        unique case (i_tok.step)
            STEP_CODE: begin
                if (i_nib == NIB_SHORT) begin
                    o_tok.kind = KIND_SHORT;
                    o_tok.step = STEP_ONE;
                end else if (i_nib == NIB_LONG && (i_mode == MODE_FULL || !low_mode)) begin
                    o_tok.kind = KIND_LONG;
                    o_tok.step = STEP_ONE;
                end else if (i_nib == NIB_ESC && !low_mode) begin
                    o_tok.kind = KIND_ESC;
                    o_tok.step = STEP_ONE;
                end else begin
                    o_res.valid = 1'b1;
                    o_res.value = {4'd0, i_nib};
                    o_res.count = 9'd1;
                end
            end
            STEP_ONE: begin
                if (i_tok.kind == KIND_ESC) begin
                    o_tok.hlow = i_nib;
                    o_tok.step = STEP_THREE;
                end else if (i_tok.kind == KIND_SHORT && low_mode && i_nib == NIB_SHORT) begin
                    // A doubled short-run code in the lower modes opens an escape byte.
                    o_tok.kind = KIND_ESC;
                    o_tok.step = STEP_TWO;
                end else begin
                    o_tok.hval = i_nib;
                    o_tok.step = STEP_TWO;
                end
            end
            STEP_TWO: begin
                if (i_tok.kind == KIND_SHORT) begin
                    o_res.valid = 1'b1;
                    o_res.value = {4'd0, i_tok.hval};
                    o_res.count = {5'd0, i_nib} + SHORT_BIAS;
                    o_tok.step  = STEP_CODE;
                end else begin
                    o_tok.hlow = i_nib;
                    o_tok.step = STEP_THREE;
                end
            end
            STEP_THREE: begin
                o_tok.step  = STEP_CODE;
                o_res.valid = 1'b1;
                if (i_tok.kind == KIND_LONG) begin
                    o_res.value = {4'd0, i_tok.hval};
                    o_res.count = {5'd0, i_tok.hlow} + LONG_BIAS + {1'b0, i_nib, 4'd0};
                end else begin
                    o_res.value = {i_nib, i_tok.hlow};
                    o_res.count = 9'd1;
                end
            end
            default: begin
                o_tok = i_tok;
            end
        endcase
    end

endmodule

### rtl/core/hrle_merge.sv
// Merges the two lane results of a byte into an in-order result queue and drives the
// output stream. Depends on hrle_pkg.
module hrle_merge (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  hrle_pkg::t_res   i_res0,
    input  hrle_pkg::t_res   i_res1,
    input  logic             i_ready,
    output logic             o_valid,
    output logic [7:0]       o_value,
    output logic [8:0]       o_count,
    output logic             o_last,
    output hrle_pkg::t_q_stat o_stat
);
    import hrle_pkg::*;

    logic [7:0] r_q_value [QDEPTH];
    logic [8:0] r_q_count [QDEPTH];
    logic       r_q_last  [QDEPTH];

    logic [QAW-1:0]  r_wptr, n_wptr;
    logic [QAW-1:0]  r_rptr, n_rptr;
    logic [LVLW-1:0] r_level, n_level;

    logic [QAW-1:0]  wa1;
    logic [1:0]      nw;
    logic            pop;
    logic            both;
    t_res            first;

    assign both  = i_res0.valid && i_res1.valid;
    assign first = i_res0.valid ? i_res0 : i_res1;
    assign nw    = i_push ? ({1'b0, i_res0.valid} + {1'b0, i_res1.valid}) : 2'd0;
    assign wa1   = r_wptr + QAW'(1);
    assign pop   = o_valid && i_ready;

    assign n_wptr  = r_wptr + QAW'(nw);
    assign n_rptr  = r_rptr + QAW'(pop);
    assign n_level = r_level + LVLW'(nw) - LVLW'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_level <= n_level;
        end
    end

    // The first result of a byte carries the last flag only when it is alone.
    always_ff @(posedge i_clk) begin
        if (i_push && (i_res0.valid || i_res1.valid)) begin
            r_q_value[r_wptr] <= first.value;
            r_q_count[r_wptr] <= first.count;
            r_q_last[r_wptr]  <= !both;
        end
        if (i_push && both) begin
            r_q_value[wa1] <= i_res1.value;
            r_q_count[wa1] <= i_res1.count;
            r_q_last[wa1]  <= 1'b1;
        end
    end

    assign o_valid = (r_level != '0);
    assign o_value = r_q_value[r_rptr];
    assign o_count = r_q_count[r_rptr];
    assign o_last  = r_q_last[r_rptr];

    assign o_stat.level = r_level;
    assign o_stat.room  = (r_level <= LVLW'(QDEPTH - 2));

endmodule

### rtl/core/halfbyte_rle_decoder.sv
// Top level of the half-byte run-length decoder: token state, mode register, two parser
// lanes and the result queue. Depends on hrle_pkg, hrle_lane and hrle_merge.
//
//  Channel  | Direction | Carries
//  ---------+-----------+---------------------------------------------------------
//  s_*      | in        | one compressed byte per transfer, tlast ends the stream
//  m_*      | out       | one run descriptor (value, count) per transfer
//  APB      | in/out    | mode register at byte address 0
//
// A byte is parsed in the cycle of its transfer: lane 0 takes the high nibble, lane 1 the
// low nibble from lane 0's token state, and the 0..2 results enter a four-entry queue.
// The first result can leave on the next cycle. A byte is taken every cycle while the queue
// holds two results or fewer, so one byte per cycle is sustained while results drain.
// Synchronous active-low reset empties the queue and clears the token state and mode.
// A stalled output only stops input once the queue cannot hold two more results.
module halfbyte_rle_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_value, [16:8] out_count, [23:17] zero
    output logic        m_tlast,   // last_of_item
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import hrle_pkg::*;

    logic [1:0] r_mode;
    t_tok       r_tok, n_tok;
    t_tok       tok_mid, tok_end;
    t_res       res0, res1;
    t_q_stat    q_stat;
    logic       accept;
    logic       cfg_wr;
    logic [7:0] m_value;
    logic [8:0] m_count;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_MODE) ? {30'd0, r_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_FULL;
        end else if (cfg_wr && paddr[2] == REG_MODE) begin
            r_mode <= pwdata[1:0];
        end
    end

    hrle_lane u_lane_hi (
        .i_mode (r_mode),
        .i_tok  (r_tok),
        .i_nib  (s_tdata[7:4]),
        .o_tok  (tok_mid),
        .o_res  (res0)
    );

    hrle_lane u_lane_lo (
        .i_mode (r_mode),
        .i_tok  (tok_mid),
        .i_nib  (s_tdata[3:0]),
        .o_tok  (tok_end),
        .o_res  (res1)
    );

    assign accept = s_tvalid && s_tready;

    // The end of a stream drops any unfinished token.
    always_comb begin
        n_tok = r_tok;
        if (accept) begin
            n_tok = s_tlast ? TOK_RESET : tok_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= TOK_RESET;
        end else begin
            r_tok <= n_tok;
        end
    end

    hrle_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_res0  (res0),
        .i_res1  (res1),
        .i_ready (m_tready),
        .o_valid (m_tvalid),
        .o_value (m_value),
        .o_count (m_count),
        .o_last  (m_tlast),
        .o_stat  (q_stat)
    );

    assign s_tready = q_stat.room;
    assign m_tdata  = {7'd0, m_count, m_value};

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.level <= LVLW'(QDEPTH))
        else $error("result queue level beyond its depth");

    a_accept_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> q_stat.level <= LVLW'(QDEPTH - 2))
        else $error("byte taken without room for two results");

    a_valid_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid == (q_stat.level != '0))
        else $error("output valid disagrees with queue level");

    a_stream_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && s_tlast) |=> (r_tok == TOK_RESET))
        else $error("token state not cleared after the last byte");

endmodule
